// ===== design/aals_pkg.sv =====
// Shared types, widths and constants of the antialiased line stepper.
`default_nettype none

package aals_pkg;

   localparam int X_W = 10;
   localparam int Y_W = 9;
   localparam int COLOR_W = 16;
   localparam int COV_W = 8;
   // 255 * remainder, remainder below the 10-bit major length
   localparam int NUM_W = X_W + COV_W;

   localparam int SCREEN_WIDTH = 640;
   localparam int SCREEN_HEIGHT = 480;

   localparam logic [COV_W-1:0] FULL_COVER = 8'd255;

   localparam logic ACT_START = 1'b0;
   localparam logic ACT_ADVANCE = 1'b1;

   typedef enum logic [1:0] {
      MODE_VERT = 2'd0,
      MODE_HORZ = 2'd1,
      MODE_YMAJ = 2'd2,
      MODE_XMAJ = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_DIV  = 2'd1,
      ST_OUT1 = 2'd2,
      ST_OUT2 = 2'd3
   } state_type;

   // decoded start beat
   typedef struct packed {
      logic             ok;
      mode_type         mode;
      logic [X_W-1:0]   major0;
      logic [X_W-1:0]   major_end;
      logic [X_W-1:0]   minor0;
      logic [X_W-1:0]   span;
      logic [X_W-1:0]   mag;
      logic             neg;
   } line_type;

endpackage

`default_nettype wire

// ===== design/aals_ifs.sv =====
// Valid/ready channel interfaces for request and response beats.
`default_nettype none

interface aals_req_if;
   logic                          valid;
   logic                          ready;
   logic                          action;
   logic [aals_pkg::X_W-1:0]      x_start;
   logic [aals_pkg::Y_W-1:0]      y_start;
   logic [aals_pkg::X_W-1:0]      x_end;
   logic [aals_pkg::Y_W-1:0]      y_end;
   logic [aals_pkg::COLOR_W-1:0]  color;

   modport source (
      output valid, action, x_start, y_start, x_end, y_end, color,
      input  ready
   );
   modport sink (
      input  valid, action, x_start, y_start, x_end, y_end, color,
      output ready
   );
endinterface

interface aals_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [aals_pkg::X_W-1:0]      pixel_x;
   logic [aals_pkg::Y_W-1:0]      pixel_y;
   logic [aals_pkg::COLOR_W-1:0]  pixel_color;
   logic [aals_pkg::COV_W-1:0]    coverage;
   logic                          last_of_step;
   logic                          line_done;

   modport source (
      output valid, pixel_x, pixel_y, pixel_color, coverage, last_of_step, line_done,
      input  ready
   );
   modport sink (
      input  valid, pixel_x, pixel_y, pixel_color, coverage, last_of_step, line_done,
      output ready
   );
endinterface

`default_nettype wire

// ===== design/aals_setup.sv =====
// Start beat decode: bounds check, mode pick, endpoint ordering, line spans.
`default_nettype none

module aals_setup (
   input  wire logic [aals_pkg::X_W-1:0] x_start,
   input  wire logic [aals_pkg::Y_W-1:0] y_start,
   input  wire logic [aals_pkg::X_W-1:0] x_end,
   input  wire logic [aals_pkg::Y_W-1:0] y_end,
   output aals_pkg::line_type            line
);
   import aals_pkg::*;

   logic signed [X_W:0] dx;
   logic signed [Y_W:0] dy;
   logic [X_W-1:0]      adx;
   logic [Y_W-1:0]      ady;
   logic                swap;
   mode_type            mode;
   logic [X_W-1:0]      from_x, to_x;
   logic [Y_W-1:0]      from_y, to_y;
   logic                ymaj;
   logic [X_W-1:0]      minor_end;

   always_comb begin
      dx = $signed({1'b0, x_end}) - $signed({1'b0, x_start});
      dy = $signed({1'b0, y_end}) - $signed({1'b0, y_start});
      adx = dx[X_W] ? X_W'(-dx) : dx[X_W-1:0];
      ady = dy[Y_W] ? Y_W'(-dy) : dy[Y_W-1:0];

      if (dx == '0) begin
         mode = MODE_VERT;
         swap = dy[Y_W];
      end else if (dy == '0) begin
         mode = MODE_HORZ;
         swap = dx[X_W];
      end else if ({1'b0, ady} >= adx) begin
         mode = MODE_YMAJ;
         swap = dy[Y_W];
      end else begin
         mode = MODE_XMAJ;
         swap = dx[X_W];
      end

      from_x = swap ? x_end : x_start;
      to_x   = swap ? x_start : x_end;
      from_y = swap ? y_end : y_start;
      to_y   = swap ? y_start : y_end;
      ymaj   = (mode == MODE_VERT) || (mode == MODE_YMAJ);

      line.ok = ({1'b0, x_start} < (X_W+1)'(SCREEN_WIDTH)) &&
                ({1'b0, x_end} < (X_W+1)'(SCREEN_WIDTH)) &&
                ({1'b0, y_start} < (Y_W+1)'(SCREEN_HEIGHT)) &&
                ({1'b0, y_end} < (Y_W+1)'(SCREEN_HEIGHT));
      line.mode      = mode;
      line.major0    = ymaj ? {1'b0, from_y} : from_x;
      line.major_end = ymaj ? {1'b0, to_y} : to_x;
      line.minor0    = ymaj ? from_x : {1'b0, from_y};
      minor_end      = ymaj ? to_x : {1'b0, to_y};
      line.span      = line.major_end - line.major0;
      line.neg       = minor_end < line.minor0;
      line.mag       = line.neg ? (line.minor0 - minor_end) : (minor_end - line.minor0);
   end

endmodule

`default_nettype wire

// ===== design/aals_alpha_div.sv =====
// Bit-serial restoring divider for the coverage weight, one quotient bit per cycle.
`default_nettype none

module aals_alpha_div (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [aals_pkg::NUM_W-1:0]   numer,
   input  wire logic [aals_pkg::X_W-1:0]     denom,
   output logic                              done,
   output logic [aals_pkg::COV_W-1:0]        quotient
);
   import aals_pkg::*;

   localparam int CNT_W = $clog2(COV_W);

   logic             active_ff, active_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [X_W-1:0]   rem_ff, rem_in;
   logic [X_W-1:0]   den_ff, den_in;
   logic [COV_W-1:0] num_ff, num_in;
   logic [COV_W-1:0] quo_ff, quo_in;
   logic [X_W:0]     trial;
   logic             fits;

   always_comb begin
      // quotient is known to fit COV_W bits, so the high part starts below the divisor
      trial     = {rem_ff, num_ff[COV_W-1]};
      fits      = trial >= {1'b0, den_ff};
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      num_in    = num_ff;
      quo_in    = quo_ff;
      if (start) begin
         active_in = 1'b1;
         cnt_in    = '0;
         rem_in    = numer[NUM_W-1:COV_W];
         num_in    = numer[COV_W-1:0];
         den_in    = denom;
      end else if (active_ff) begin
         rem_in = fits ? X_W'(trial - {1'b0, den_ff}) : trial[X_W-1:0];
         num_in = {num_ff[COV_W-2:0], 1'b0};
         quo_in = {quo_ff[COV_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(COV_W-1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         cnt_ff    <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !active_ff) else $error("divider restarted while busy");
   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> rem_ff < den_ff) else $error("partial remainder not below divisor");
   a_done_after_run: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(active_ff) && !active_ff) else $error("done without a run");

endmodule

`default_nettype wire

// ===== design/antialiased_line_stepper.sv =====
// Top level: line state, step walker, coverage sequencing and output register.
//
//   channel   dir   beat contents
//   req_chan  in    action, x_start, y_start, x_end, y_end, color
//   rsp_chan  out   pixel_x, pixel_y, pixel_color, coverage, last_of_step, line_done
//
// A start beat and an ignored advance leave the step machine in idle.
// An advance with a full-coverage pixel goes straight to a single write; an antialiased
// one runs the bit-serial coverage divider, then writes the pixel and, for a nonzero weight, its neighbor.
// The minor position is walked incrementally, one add/compare per step.
// Output stalls hold the step machine; a finished beat waits in the output register
// while the next request is taken. Synchronous reset returns to idle, no line.
`default_nettype none

module antialiased_line_stepper (
   input  wire logic   clock,
   input  wire logic   reset,
   aals_req_if.sink    req_chan,
   aals_rsp_if.source  rsp_chan
);
   import aals_pkg::*;

   state_type            state_ff, state_in;
   line_type             setup_line;

   logic                 drawing_ff;
   mode_type             mode_ff;
   logic [X_W-1:0]       major_pos_ff;
   logic [X_W-1:0]       end_ff;
   logic [X_W-1:0]       minor0_ff;
   logic [X_W-1:0]       span_ff;
   logic [X_W-1:0]       mag_ff;
   logic                 neg_ff;
   logic [X_W-1:0]       q_ff;
   logic [X_W-1:0]       r_ff;
   logic [COLOR_W-1:0]   color_ff;

   logic [X_W-1:0]       res_x_ff, alt_x_ff;
   logic [Y_W-1:0]       res_y_ff, alt_y_ff;
   logic                 plain_ff;
   logic                 fin_ff;

   logic                 rsp_valid_ff;
   logic [X_W-1:0]       rsp_x_ff;
   logic [Y_W-1:0]       rsp_y_ff;
   logic [COLOR_W-1:0]   rsp_color_ff;
   logic [COV_W-1:0]     rsp_cov_ff;
   logic                 rsp_last_ff;
   logic                 rsp_done_ff;

   logic                 accept, start_go, step_go;
   logic                 ymaj, is_major, plain, step_done;
   logic [X_W-1:0]       minor, minor_alt;
   logic [X_W:0]         r_sum;
   logic                 r_wrap;
   logic [NUM_W-1:0]     numer;
   logic                 div_start, div_done;
   logic [COV_W-1:0]     alpha;
   logic                 out_free, load_out;
   logic [X_W-1:0]       out_x;
   logic [Y_W-1:0]       out_y;
   logic [COV_W-1:0]     out_cov;
   logic                 out_last, out_done, last1;

   aals_setup u_setup (
      .x_start (req_chan.x_start),
      .y_start (req_chan.y_start),
      .x_end   (req_chan.x_end),
      .y_end   (req_chan.y_end),
      .line    (setup_line)
   );

   aals_alpha_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (numer),
      .denom    (span_ff),
      .done     (div_done),
      .quotient (alpha)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept   = req_chan.valid & req_chan.ready;
   assign start_go = accept & (req_chan.action == ACT_START);
   assign step_go  = accept & (req_chan.action == ACT_ADVANCE) & drawing_ff;

   always_comb begin
      ymaj      = (mode_ff == MODE_VERT) || (mode_ff == MODE_YMAJ);
      is_major  = (mode_ff == MODE_YMAJ) || (mode_ff == MODE_XMAJ);
      plain     = !is_major || (r_ff == '0);
      step_done = major_pos_ff >= end_ff;
      minor     = neg_ff ? (minor0_ff - q_ff) : (minor0_ff + q_ff);
      // neighbor toward the sign of the remainder
      minor_alt = neg_ff ? (minor - 1'b1) : (minor + 1'b1);
      r_sum     = {1'b0, r_ff} + {1'b0, mag_ff};
      r_wrap    = r_sum >= {1'b0, span_ff};
      // 255 * r
      numer     = {r_ff, {COV_W{1'b0}}} - {{COV_W{1'b0}}, r_ff};
   end

   // step sequencer
   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      load_out  = 1'b0;
      out_free  = !rsp_valid_ff || rsp_chan.ready;
      last1     = plain_ff || (alpha == '0);
      out_x     = res_x_ff;
      out_y     = res_y_ff;
      out_cov   = plain_ff ? FULL_COVER : (FULL_COVER - alpha);
      out_last  = last1;
      out_done  = last1 & fin_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (step_go) begin
               div_start = !plain;
               state_in  = plain ? ST_OUT1 : ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) state_in = ST_OUT1;
         end
         ST_OUT1: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = last1 ? ST_IDLE : ST_OUT2;
            end
         end
         ST_OUT2: begin
            out_x    = alt_x_ff;
            out_y    = alt_y_ff;
            out_cov  = alpha;
            out_last = 1'b1;
            out_done = fin_ff;
            if (out_free) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         drawing_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (start_go) begin
            drawing_ff <= setup_line.ok;
         end else if (step_go && step_done) begin
            drawing_ff <= 1'b0;
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // line state and walker
   always_ff @(posedge clock) begin
      if (start_go && setup_line.ok) begin
         mode_ff      <= setup_line.mode;
         major_pos_ff <= setup_line.major0;
         end_ff       <= setup_line.major_end;
         minor0_ff    <= setup_line.minor0;
         span_ff      <= setup_line.span;
         mag_ff       <= setup_line.mag;
         neg_ff       <= setup_line.neg;
         q_ff         <= '0;
         r_ff         <= '0;
         color_ff     <= req_chan.color;
      end else if (step_go) begin
         res_x_ff <= ymaj ? minor : major_pos_ff;
         res_y_ff <= ymaj ? major_pos_ff[Y_W-1:0] : minor[Y_W-1:0];
         alt_x_ff <= ymaj ? minor_alt : major_pos_ff;
         alt_y_ff <= ymaj ? major_pos_ff[Y_W-1:0] : minor_alt[Y_W-1:0];
         plain_ff <= plain;
         fin_ff   <= step_done;
         if (!step_done) begin
            major_pos_ff <= major_pos_ff + 1'b1;
            if (is_major) begin
               q_ff <= r_wrap ? (q_ff + 1'b1) : q_ff;
               r_ff <= r_wrap ? X_W'(r_sum - {1'b0, span_ff}) : r_sum[X_W-1:0];
            end
         end
      end
   end

   // color travels with the beat so a new start cannot alter a waiting pixel
   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_x_ff     <= out_x;
         rsp_y_ff     <= out_y;
         rsp_color_ff <= color_ff;
         rsp_cov_ff   <= out_cov;
         rsp_last_ff  <= out_last;
         rsp_done_ff  <= out_done;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.pixel_x      = rsp_x_ff;
   assign rsp_chan.pixel_y      = rsp_y_ff;
   assign rsp_chan.pixel_color  = rsp_color_ff;
   assign rsp_chan.coverage     = rsp_cov_ff;
   assign rsp_chan.last_of_step = rsp_last_ff;
   assign rsp_chan.line_done    = rsp_done_ff;

   a_cov_nonzero: assert property (@(posedge clock) disable iff (reset)
      load_out |=> rsp_cov_ff != '0) else $error("zero-coverage beat emitted");
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      load_out && out_done |-> out_last) else $error("line end not on last beat of step");
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      drawing_ff && is_major |-> r_ff < span_ff) else $error("walker remainder out of range");
   a_div_only_aa: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> !plain_ff) else $error("divide on a full-coverage step");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the antialiased line stepper: directed table, then random lines.
`timescale 1ns / 1ps

module tb;
   import aals_pkg::*;

   localparam int TAIL_CYCLES = 40;
   localparam int RANDOM_BEATS = 1300;

   typedef struct {
      logic               action;
      logic [X_W-1:0]     x_start;
      logic [Y_W-1:0]     y_start;
      logic [X_W-1:0]     x_end;
      logic [Y_W-1:0]     y_end;
      logic [COLOR_W-1:0] color;
   } line_cmd_type;

   typedef struct {
      logic [X_W-1:0]     x;
      logic [Y_W-1:0]     y;
      logic [COLOR_W-1:0] color;
      logic [COV_W-1:0]   cov;
      logic               last;
      logic               done;
   } pixel_type;

   // n_fixed < 0: pixels come from the line predictor, else 0 or 1 typed-in pixel
   typedef struct {
      line_cmd_type cmd;
      int           n_fixed;
      pixel_type    fixed;
   } stim_row_type;

   typedef enum {RX_FREE, RX_LIGHT, RX_HEAVY} rx_mode_type;

   logic clock;
   logic reset;

   aals_req_if req_bus ();
   aals_rsp_if rsp_bus ();

   antialiased_line_stepper i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // predicted line state
   logic               ln_active;
   mode_type           ln_mode;
   logic [X_W-1:0]     ln_from_x, ln_to_x, ln_major;
   logic [Y_W-1:0]     ln_from_y, ln_to_y;
   logic [COLOR_W-1:0] ln_color;

   pixel_type pending_pixels[$];
   int        mismatches = 0;
   int        beats_counted = 0;
   int        burst_left = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("tb: FAIL");
      $finish;
   end

   function automatic pixel_type place_pixel(pixel_type p, logic ymaj, int mj, int mn);
      if (ymaj) begin
         p.x = mn[X_W-1:0];
         p.y = mj[Y_W-1:0];
      end else begin
         p.x = mj[X_W-1:0];
         p.y = mn[Y_W-1:0];
      end
      return p;
   endfunction

   // Applies one beat to the predicted line state; returns the pixels it writes.
   function automatic int plot_step(input line_cmd_type c, output pixel_type px[2]);
      int        dx, dy, adx, ady, endv, mj, mj0, mj1, mn0, mn1, v, u, mn, w, alpha, n;
      logic      swap, ymaj, done;
      pixel_type p;
      if (c.action == ACT_START) begin
         ln_active = 1'b0;
         if (c.x_start >= SCREEN_WIDTH || c.x_end >= SCREEN_WIDTH ||
             c.y_start >= SCREEN_HEIGHT || c.y_end >= SCREEN_HEIGHT)
            return 0;
         ln_color = c.color;
         dx = int'(c.x_end) - int'(c.x_start);
         dy = int'(c.y_end) - int'(c.y_start);
         adx = dx < 0 ? -dx : dx;
         ady = dy < 0 ? -dy : dy;
         if (dx == 0) begin
            ln_mode = MODE_VERT;
            swap = dy < 0;
         end else if (dy == 0) begin
            ln_mode = MODE_HORZ;
            swap = dx < 0;
         end else if (ady >= adx) begin
            ln_mode = MODE_YMAJ;
            swap = dy < 0;
         end else begin
            ln_mode = MODE_XMAJ;
            swap = dx < 0;
         end
         ln_from_x = swap ? c.x_end : c.x_start;
         ln_from_y = swap ? c.y_end : c.y_start;
         ln_to_x   = swap ? c.x_start : c.x_end;
         ln_to_y   = swap ? c.y_start : c.y_end;
         ln_major  = (ln_mode == MODE_VERT || ln_mode == MODE_YMAJ) ?
                     {1'b0, ln_from_y} : ln_from_x;
         ln_active = 1'b1;
         return 0;
      end

      if (!ln_active)
         return 0;

      ymaj = ln_mode == MODE_VERT || ln_mode == MODE_YMAJ;
      endv = ymaj ? int'(ln_to_y) : int'(ln_to_x);
      done = int'(ln_major) >= endv;
      mj = int'(ln_major);
      p.color = ln_color;
      p.cov = FULL_COVER;
      p.last = 1'b1;
      p.done = done;
      n = 1;
      if (ln_mode == MODE_VERT) begin
         p = place_pixel(p, 1'b1, mj, int'(ln_from_x));
      end else if (ln_mode == MODE_HORZ) begin
         p = place_pixel(p, 1'b0, mj, int'(ln_from_y));
      end else begin
         mj0 = ymaj ? int'(ln_from_y) : int'(ln_from_x);
         mj1 = ymaj ? int'(ln_to_y) : int'(ln_to_x);
         mn0 = ymaj ? int'(ln_from_x) : int'(ln_from_y);
         mn1 = ymaj ? int'(ln_to_x) : int'(ln_to_y);
         v = mj1 - mj0;
         if (v <= 0)
            v = 1;
         u = (mn1 - mn0) * (mj - mj0);
         mn = mn0 + u / v;
         w = u % v;
         // a remainder too small to give the neighbor any weight is a plain pixel
         alpha = (int'(FULL_COVER) * (w < 0 ? -w : w)) / v;
         p.cov = FULL_COVER - alpha[COV_W-1:0];
         p.last = alpha == 0;
         p.done = alpha == 0 && done;
         p = place_pixel(p, ymaj, mj, mn);
         if (alpha != 0) begin
            px[1] = place_pixel(p, ymaj, mj, w > 0 ? mn + 1 : mn - 1);
            px[1].cov = alpha[COV_W-1:0];
            px[1].last = 1'b1;
            px[1].done = done;
            n = 2;
         end
      end
      px[0] = p;

      if (done)
         ln_active = 1'b0;
      else
         ln_major = ln_major + 1'b1;
      return n;
   endfunction

   function automatic int field_bad(string name, logic [31:0] want, logic [31:0] got);
      if (got === want)
         return 0;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      return 1;
   endfunction

   always @(posedge clock) begin : watch_pixels
      pixel_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_pixels.size() == 0) begin
            $display("%0t: pixel (%0d,%0d) with none expected",
                     $time, rsp_bus.pixel_x, rsp_bus.pixel_y);
            mismatches++;
         end else begin
            want = pending_pixels.pop_front();
            mismatches += field_bad("pixel_x", want.x, rsp_bus.pixel_x);
            mismatches += field_bad("pixel_y", want.y, rsp_bus.pixel_y);
            mismatches += field_bad("pixel_color", want.color, rsp_bus.pixel_color);
            mismatches += field_bad("coverage", want.cov, rsp_bus.coverage);
            mismatches += field_bad("last_of_step", want.last, rsp_bus.last_of_step);
            mismatches += field_bad("line_done", want.done, rsp_bus.line_done);
         end
      end
   end

   // receiver: phases of free flow, short hiccups and long stalls
   initial begin : rsp_stall
      rx_mode_type rx_mode;
      int          phase_left;
      int          stall_left;
      rsp_bus.ready = 1'b0;
      phase_left = 0;
      stall_left = 0;
      rx_mode = RX_FREE;
      forever begin
         @(negedge clock);
         if (phase_left == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 2));
            phase_left = $urandom_range(50, 300);
         end
         phase_left--;
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready = 1'b0;
         end else begin
            rsp_bus.ready = 1'b1;
            case (rx_mode)
               RX_LIGHT: if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 2);
               RX_HEAVY: if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 20);
               default: ;
            endcase
         end
      end
   end

   task automatic drive_beat(input line_cmd_type c, input int n_fixed, input pixel_type fixed);
      pixel_type px[2];
      int        n;
      @(negedge clock);
      if (burst_left == 0) begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) :
                      $urandom_range(1, 10);
      end
      burst_left--;
      req_bus.action  = c.action;
      req_bus.x_start = c.x_start;
      req_bus.y_start = c.y_start;
      req_bus.x_end   = c.x_end;
      req_bus.y_end   = c.y_end;
      req_bus.color   = c.color;
      req_bus.valid   = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      n = plot_step(c, px);
      if (n_fixed >= 0) begin
         n = n_fixed;
         px[0] = fixed;
      end
      for (int k = 0; k < n; k++)
         pending_pixels.push_back(px[k]);
      if (c.action == ACT_START || n > 0)
         beats_counted++;
   endtask

   task automatic drain_pixels();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (pending_pixels.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
   endtask

   function automatic stim_row_type start_row(logic [X_W-1:0] xs, logic [Y_W-1:0] ys,
                                              logic [X_W-1:0] xe, logic [Y_W-1:0] ye,
                                              logic [COLOR_W-1:0] col);
      stim_row_type r;
      r.cmd = '{ACT_START, xs, ys, xe, ye, col};
      r.n_fixed = 0;
      r.fixed = '{default: '0};
      return r;
   endfunction

   function automatic stim_row_type adv_row(int n_fixed, int fx = 0, int fy = 0,
                                            logic [COLOR_W-1:0] fcol = '0,
                                            logic [COV_W-1:0] fcov = '0,
                                            logic flast = 1'b0, logic fdone = 1'b0);
      stim_row_type r;
      // start fields are don't-care on an advance; drive all ones
      r.cmd = '{ACT_ADVANCE, '1, '1, '1, '1, '1};
      r.n_fixed = n_fixed;
      r.fixed = '{fx[X_W-1:0], fy[Y_W-1:0], fcol, fcov, flast, fdone};
      return r;
   endfunction

   function automatic logic [X_W-1:0] clamp_coord(int v, int hi);
      if (v < 0)
         v = 0;
      if (v > hi)
         v = hi;
      return v[X_W-1:0];
   endfunction

   task automatic random_line();
      line_cmd_type c;
      pixel_type    unused_px;
      int           pick, span, dx, dy, limit, steps;
      unused_px = '{default: '0};
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         // noise beat: any action, endpoints anywhere incl. off screen
         c.action  = 1'($urandom_range(0, 1));
         c.x_start = X_W'($urandom);
         c.y_start = Y_W'($urandom);
         c.x_end   = X_W'($urandom);
         c.y_end   = Y_W'($urandom);
         c.color   = COLOR_W'($urandom);
         drive_beat(c, -1, unused_px);
         return;
      end
      span = $urandom_range(0, 99);
      span = span < 90 ? 12 : (span < 99 ? 60 : SCREEN_WIDTH - 1);
      dx = int'($urandom_range(0, 2 * span)) - span;
      dy = int'($urandom_range(0, 2 * span)) - span;
      case (pick)
         1: dx = 0;
         2: dy = 0;
         3: begin
            dx = 0;
            dy = 0;
         end
         4: dy = $urandom_range(0, 1) ? dx : -dx;
         default: ;
      endcase
      c.action  = ACT_START;
      c.x_start = X_W'($urandom_range(0, SCREEN_WIDTH - 1));
      c.y_start = Y_W'($urandom_range(0, SCREEN_HEIGHT - 1));
      c.x_end   = clamp_coord(int'(c.x_start) + dx, SCREEN_WIDTH - 1);
      c.y_end   = Y_W'(clamp_coord(int'(c.y_start) + dy, SCREEN_HEIGHT - 1));
      c.color   = COLOR_W'($urandom);
      drive_beat(c, -1, unused_px);

      // mostly walk the line to its end; sometimes cut it short with the next start
      limit = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 8) : 1 << 20;
      steps = 0;
      while (ln_active && steps < limit) begin
         c.action  = ACT_ADVANCE;
         c.x_start = X_W'($urandom);
         c.y_start = Y_W'($urandom);
         c.x_end   = X_W'($urandom);
         c.y_end   = Y_W'($urandom);
         c.color   = COLOR_W'($urandom);
         drive_beat(c, -1, unused_px);
         steps++;
      end
      if ($urandom_range(0, 9) == 0) begin
         c.action = ACT_ADVANCE;
         drive_beat(c, -1, unused_px);
      end
   endtask

   initial begin : stimulus
      stim_row_type dir_rows[$];
      bit           paused;
      reset = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.action  = ACT_START;
      req_bus.x_start = '0;
      req_bus.y_start = '0;
      req_bus.x_end   = '0;
      req_bus.y_end   = '0;
      req_bus.color   = '0;
      ln_active = 1'b0;
      ln_mode   = MODE_VERT;
      ln_from_x = '0;
      ln_from_y = '0;
      ln_to_x   = '0;
      ln_to_y   = '0;
      ln_color  = '0;
      ln_major  = '0;
      paused = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      dir_rows = '{
         adv_row(0),                                          // advance while idle
         start_row(640, 0, 0, 0, 16'h0F0F),                   // column off screen
         adv_row(0),
         start_row(5, 7, 5, 7, 16'hFFFF),                     // single point
         adv_row(1, 5, 7, 16'hFFFF, FULL_COVER, 1'b1, 1'b1),
         adv_row(0),
         start_row(639, 479, 639, 479, 16'h0000),             // far corner
         adv_row(1, 639, 479, 16'h0000, FULL_COVER, 1'b1, 1'b1),
         start_row(1, 479, 0, 479, 16'h1234),                 // horizontal, swapped
         adv_row(1, 0, 479, 16'h1234, FULL_COVER, 1'b1, 1'b0),
         adv_row(1, 1, 479, 16'h1234, FULL_COVER, 1'b1, 1'b1),
         start_row(0, 1, 0, 0, 16'hF800),                     // vertical, swapped
         adv_row(1, 0, 0, 16'hF800, FULL_COVER, 1'b1, 1'b0),
         start_row(3, 3, 3, 480, 16'h5555),                   // row off screen drops the line
         adv_row(0),
         start_row(0, 0, 1, 3, 16'h07E0),                     // y-major
         adv_row(-1),
         adv_row(-1),
         adv_row(-1),
         adv_row(-1),
         start_row(10, 20, 3, 18, 16'h001F),                  // x-major, swapped
         adv_row(-1),
         adv_row(-1),
         adv_row(-1)
      };
      foreach (dir_rows[i])
         drive_beat(dir_rows[i].cmd, dir_rows[i].n_fixed, dir_rows[i].fixed);

      drain_pixels();
      beats_counted = 0;
      while (beats_counted < RANDOM_BEATS) begin
         random_line();
         if (!paused && beats_counted >= RANDOM_BEATS / 2) begin
            drain_pixels();
            paused = 1'b1;
         end
      end

      @(negedge clock);
      req_bus.valid = 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_pixels.size() == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/aals_pkg.sv
design/aals_ifs.sv
design/aals_setup.sv
design/aals_alpha_div.sv
design/antialiased_line_stepper.sv
dv/tb.sv
